### hw/rtl/mbg_pkg.sv
// Package for the maze backtracker generator.
// Holds sizes, action, event and cell codes, the item structs and direction offsets.
// No dependencies; the top level and the testbench import it, mbg_ram does not.
`timescale 1ns / 1ps
`default_nettype none

package mbg_pkg;

    // Grid and storage sizes.
    localparam int MAX_DIM     = 64;
    localparam int DIM_W       = $clog2(MAX_DIM);
    localparam int MAP_AW      = 2 * DIM_W;
    localparam int STACK_DEPTH = 1024;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W       = 11;
    localparam int REG_W       = 7;

    // Configuration register indexes.
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // Input actions.
    localparam logic [1:0] ACT_STEP  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;

    // Result events.
    localparam logic [2:0] EV_MOVED    = 3'd0;
    localparam logic [2:0] EV_BACK     = 3'd1;
    localparam logic [2:0] EV_REJECT   = 3'd2;
    localparam logic [2:0] EV_FINISHED = 3'd3;
    localparam logic [2:0] EV_STARTED  = 3'd4;
    localparam logic [2:0] EV_READ     = 3'd5;

    // Cell codes of a read reply.
    localparam logic [2:0] CELL_WALL      = 3'd0;
    localparam logic [2:0] CELL_UNVISITED = 3'd1;
    localparam logic [2:0] CELL_PASSAGE   = 3'd2;
    localparam logic [2:0] CELL_GOAL      = 3'd3;
    localparam logic [2:0] CELL_START     = 3'd4;

    // Directions.
    localparam logic [1:0] DIR_ROW_INC = 2'd0;
    localparam logic [1:0] DIR_ROW_DEC = 2'd1;
    localparam logic [1:0] DIR_COL_INC = 2'd2;
    localparam logic [1:0] DIR_COL_DEC = 2'd3;

    typedef struct packed {
        logic [1:0]       action;
        logic [1:0]       rand_dir;
        logic [DIM_W-1:0] read_row;
        logic [DIM_W-1:0] read_col;
    } item_t;

    typedef struct packed {
        logic [2:0]       event_res;
        logic [DIM_W-1:0] walker_row;
        logic [DIM_W-1:0] walker_col;
        logic [2:0]       cell_code;
        logic [DIM_W-1:0] goal_row;
        logic [DIM_W-1:0] goal_col;
        logic [CNT_W-1:0] stack_depth;
        logic [CNT_W-1:0] remaining_cells;
    } result_t;

    // Row offset of a direction, two cells.
    function automatic logic signed [DIM_W+1:0] dir_dr(input logic [1:0] d);
        logic signed [DIM_W+1:0] v;
        case (d)
            DIR_ROW_INC: v = 2;
            DIR_ROW_DEC: v = -2;
            default:     v = 0;
        endcase
        return v;
    endfunction

    // Column offset of a direction, two cells.
    function automatic logic signed [DIM_W+1:0] dir_dc(input logic [1:0] d);
        logic signed [DIM_W+1:0] v;
        case (d)
            DIR_COL_INC: v = 2;
            DIR_COL_DEC: v = -2;
            default:     v = 0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mbg_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Used for the carved map and the ancestor stack; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module mbg_ram #(
    parameter int DW = 1,
    parameter int AW = 4
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] addr,
    input  wire logic [DW-1:0] wdata,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    // Write, and read with a registered output.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

### hw/rtl/maze_backtracker_generator.sv
// Top level of the maze backtracker generator: sequencer, registers, results.
// Depends on mbg_pkg and two mbg_ram instances (carved map, ancestor stack).
//
//  channel   ports                         direction  handshake
//  item      start, busy, item             in         start && !busy
//  result    done, result                  out        done, one cycle
//  config    cfg_we, cfg_index, cfg_data   in         cfg_we
//
// A move makes four neighbour reads and two carve writes, which share the single
// port of the map memory. A backtrack, a rejected draw and a dead end at the root
// make the four reads only, and a step after the finish uses no memory.
// A start runs a clearing pass over the 4096 map entries, then carves the start cell.
// After reset the same clearing pass runs, with busy high.
// Results cannot be stalled; each is shown for one cycle while busy is low.
`timescale 1ns / 1ps
`default_nettype none

module maze_backtracker_generator (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire mbg_pkg::item_t               item,
    output logic                              done,
    output mbg_pkg::result_t                  result,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_index,
    input  wire logic [mbg_pkg::REG_W-1:0]    cfg_data
);

    import mbg_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_NB    = 3'd3;
    localparam logic [2:0] S_DEC   = 3'd4;
    localparam logic [2:0] S_MV    = 3'd5;
    localparam logic [2:0] S_POP   = 3'd6;
    localparam logic [2:0] S_READ  = 3'd7;

    localparam int SW = DIM_W + 2;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        k_reg, k_next;
    logic [3:0]        ok_reg, ok_next;
    logic              odd_prev_reg, odd_prev_next;
    logic [MAP_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clr_start_reg, clr_start_next;
    logic [1:0]        dir_reg, dir_next;
    logic [DIM_W-1:0]  rd_row_reg, rd_row_next, rd_col_reg, rd_col_next;
    logic [REG_W-1:0]  width_reg, height_reg;
    logic [DIM_W-1:0]  walker_row_reg, walker_row_next, walker_col_reg, walker_col_next;
    logic [CNT_W-1:0]  depth_reg, depth_next, max_depth_reg, max_depth_next;
    logic [DIM_W-1:0]  goal_row_reg, goal_row_next, goal_col_reg, goal_col_next;
    logic              goal_valid_reg, goal_valid_next;
    logic [CNT_W-1:0]  unvisited_reg, unvisited_next;
    logic              finished_reg, finished_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;
    logic [2:0]        ev_next, code_next;

    logic                map_we, map_wdata, map_rdata;
    logic [MAP_AW-1:0]   map_addr;
    logic                stk_we;
    logic [STACK_AW-1:0] stk_addr;
    logic [2*DIM_W-1:0]  stk_wdata, stk_rdata;

    logic [REG_W-1:0]       h_eff, w_eff;
    logic signed [SW-1:0]   nb_r, nb_c, tg_r, tg_c, wl_r, wl_c;
    logic                   nb_odd, rd_odd;
    logic [3:0]             ok_all;
    logic [REG_W-2:0]       half_h, half_w;
    logic [2*REG_W-3:0]     cell_prod;
    logic [CNT_W-1:0]       depth_inc;

    // Clamp a dimension register to 3 .. MAX_DIM.
    function automatic logic [REG_W-1:0] eff_dim(input logic [REG_W-1:0] v);
        logic [REG_W-1:0] e;
        if (v < REG_W'(3))
        begin
            e = REG_W'(3);
        end
        else if (v > REG_W'(MAX_DIM))
        begin
            e = REG_W'(MAX_DIM);
        end
        else
        begin
            e = v;
        end
        return e;
    endfunction

    // True for an odd interior cell of the current grid.
    function automatic logic odd_cell(input logic signed [SW-1:0] r,
                                      input logic signed [SW-1:0] c,
                                      input logic [REG_W-1:0] h,
                                      input logic [REG_W-1:0] w);
        logic signed [SW-1:0] rmax, cmax;
        rmax = $signed({1'b0, h}) - SW'(2);
        cmax = $signed({1'b0, w}) - SW'(2);
        return (r >= SW'(1)) && (r <= rmax) && r[0]
            && (c >= SW'(1)) && (c <= cmax) && c[0];
    endfunction

    assign h_eff = eff_dim(height_reg);
    assign w_eff = eff_dim(width_reg);

    // Neighbour, target and wall coordinates around the walker.
    assign nb_r = $signed({2'b00, walker_row_reg}) + dir_dr(k_reg);
    assign nb_c = $signed({2'b00, walker_col_reg}) + dir_dc(k_reg);
    assign tg_r = $signed({2'b00, walker_row_reg}) + dir_dr(dir_reg);
    assign tg_c = $signed({2'b00, walker_col_reg}) + dir_dc(dir_reg);
    assign wl_r = $signed({2'b00, walker_row_reg}) + (dir_dr(dir_reg) >>> 1);
    assign wl_c = $signed({2'b00, walker_col_reg}) + (dir_dc(dir_reg) >>> 1);
    assign nb_odd = odd_cell(nb_r, nb_c, h_eff, w_eff);
    assign rd_odd = odd_cell($signed({2'b00, rd_row_reg}), $signed({2'b00, rd_col_reg}),
                             h_eff, w_eff);
    assign ok_all = {odd_prev_reg && !map_rdata, ok_reg[2:0]};

    // Number of odd cells of the grid, for a start.
    assign half_h    = (REG_W-1)'((h_eff - REG_W'(1)) >> 1);
    assign half_w    = (REG_W-1)'((w_eff - REG_W'(1)) >> 1);
    assign cell_prod = half_h * half_w;
    assign depth_inc = depth_reg + CNT_W'(1);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= REG_W'(11);
            height_reg <= REG_W'(11);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    // Sequencer and memory port control.
    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        ok_next         = ok_reg;
        odd_prev_next   = odd_prev_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_start_next  = clr_start_reg;
        dir_next        = dir_reg;
        rd_row_next     = rd_row_reg;
        rd_col_next     = rd_col_reg;
        walker_row_next = walker_row_reg;
        walker_col_next = walker_col_reg;
        depth_next      = depth_reg;
        max_depth_next  = max_depth_reg;
        goal_row_next   = goal_row_reg;
        goal_col_next   = goal_col_reg;
        goal_valid_next = goal_valid_reg;
        unvisited_next  = unvisited_reg;
        finished_next   = finished_reg;
        done_next       = 1'b0;
        ev_next         = EV_READ;
        code_next       = CELL_WALL;
        map_we          = 1'b0;
        map_wdata       = 1'b0;
        map_addr        = {item.read_row, item.read_col};
        stk_we          = 1'b0;
        stk_addr        = depth_reg[STACK_AW-1:0];
        stk_wdata       = {walker_row_reg, walker_col_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (item.action)
                        ACT_START:
                        begin
                            walker_row_next = DIM_W'(1);
                            walker_col_next = DIM_W'(1);
                            depth_next      = '0;
                            max_depth_next  = '0;
                            goal_row_next   = '0;
                            goal_col_next   = '0;
                            goal_valid_next = 1'b0;
                            unvisited_next  = CNT_W'(cell_prod - 1'b1);
                            finished_next   = 1'b0;
                            clr_start_next  = 1'b1;
                            clr_cnt_next    = '0;
                            state_next      = S_CLEAR;
                        end
                        ACT_STEP:
                        begin
                            dir_next = item.rand_dir;
                            if (finished_reg || unvisited_reg == '0)
                            begin
                                finished_next = 1'b1;
                                ev_next       = EV_FINISHED;
                                done_next     = 1'b1;
                            end
                            else
                            begin
                                k_next     = '0;
                                state_next = S_NB;
                            end
                        end
                        default:
                        begin
                            rd_row_next = item.read_row;
                            rd_col_next = item.read_col;
                            state_next  = S_READ;
                        end
                    endcase
                end
            end
            S_CLEAR:
            begin
                map_we       = 1'b1;
                map_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + MAP_AW'(1);
                if (clr_cnt_reg == '1)
                begin
                    state_next = clr_start_reg ? S_INIT : S_IDLE;
                end
            end
            S_INIT:
            begin
                map_we    = 1'b1;
                map_wdata = 1'b1;
                map_addr  = {DIM_W'(1), DIM_W'(1)};
                ev_next   = EV_STARTED;
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            S_NB:
            begin
                // Read neighbour k; the data of neighbour k-1 arrives now.
                map_addr      = {nb_r[DIM_W-1:0], nb_c[DIM_W-1:0]};
                odd_prev_next = nb_odd;
                ok_next[k_reg - 2'd1] = odd_prev_reg && !map_rdata;
                k_next        = k_reg + 2'd1;
                if (k_reg == 2'd3)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (ok_all == '0)
                begin
                    if (depth_reg == '0)
                    begin
                        finished_next = 1'b1;
                        ev_next       = EV_FINISHED;
                        done_next     = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        stk_addr   = STACK_AW'(depth_reg - CNT_W'(1));
                        state_next = S_POP;
                    end
                end
                else if (!ok_all[dir_reg] || depth_reg >= CNT_W'(STACK_DEPTH))
                begin
                    ev_next    = EV_REJECT;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    // Push the walker and carve the wall between.
                    stk_we     = 1'b1;
                    map_we     = 1'b1;
                    map_wdata  = 1'b1;
                    map_addr   = {wl_r[DIM_W-1:0], wl_c[DIM_W-1:0]};
                    state_next = S_MV;
                end
            end
            S_MV:
            begin
                map_we          = 1'b1;
                map_wdata       = 1'b1;
                map_addr        = {tg_r[DIM_W-1:0], tg_c[DIM_W-1:0]};
                walker_row_next = tg_r[DIM_W-1:0];
                walker_col_next = tg_c[DIM_W-1:0];
                depth_next      = depth_inc;
                if (unvisited_reg != '0)
                begin
                    unvisited_next = unvisited_reg - CNT_W'(1);
                end
                if (depth_inc > max_depth_reg)
                begin
                    max_depth_next  = depth_inc;
                    goal_row_next   = tg_r[DIM_W-1:0];
                    goal_col_next   = tg_c[DIM_W-1:0];
                    goal_valid_next = 1'b1;
                end
                ev_next    = EV_MOVED;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_POP:
            begin
                walker_row_next = stk_rdata[2*DIM_W-1:DIM_W];
                walker_col_next = stk_rdata[DIM_W-1:0];
                depth_next      = depth_reg - CNT_W'(1);
                ev_next         = EV_BACK;
                done_next       = 1'b1;
                state_next      = S_IDLE;
            end
            S_READ:
            begin
                // Cell code of the cell read in the previous cycle.
                if (map_rdata && rd_row_reg == DIM_W'(1) && rd_col_reg == DIM_W'(1))
                begin
                    code_next = CELL_START;
                end
                else if (goal_valid_reg && rd_row_reg == goal_row_reg
                         && rd_col_reg == goal_col_reg)
                begin
                    code_next = CELL_GOAL;
                end
                else if (map_rdata)
                begin
                    code_next = CELL_PASSAGE;
                end
                else if (rd_odd)
                begin
                    code_next = CELL_UNVISITED;
                end
                else
                begin
                    code_next = CELL_WALL;
                end
                ev_next    = EV_READ;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result item from the state after this item.
    always_comb
    begin
        result_next.event_res       = ev_next;
        result_next.walker_row      = walker_row_next;
        result_next.walker_col      = walker_col_next;
        result_next.cell_code       = code_next;
        result_next.goal_row        = goal_row_next;
        result_next.goal_col        = goal_col_next;
        result_next.stack_depth     = depth_next;
        result_next.remaining_cells = unvisited_next;
    end

    // Control and walk state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            k_reg          <= '0;
            ok_reg         <= '0;
            odd_prev_reg   <= 1'b0;
            clr_cnt_reg    <= '0;
            clr_start_reg  <= 1'b0;
            walker_row_reg <= DIM_W'(1);
            walker_col_reg <= DIM_W'(1);
            depth_reg      <= '0;
            max_depth_reg  <= '0;
            goal_row_reg   <= '0;
            goal_col_reg   <= '0;
            goal_valid_reg <= 1'b0;
            unvisited_reg  <= '0;
            finished_reg   <= 1'b1;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            ok_reg         <= ok_next;
            odd_prev_reg   <= odd_prev_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_start_reg  <= clr_start_next;
            walker_row_reg <= walker_row_next;
            walker_col_reg <= walker_col_next;
            depth_reg      <= depth_next;
            max_depth_reg  <= max_depth_next;
            goal_row_reg   <= goal_row_next;
            goal_col_reg   <= goal_col_next;
            goal_valid_reg <= goal_valid_next;
            unvisited_reg  <= unvisited_next;
            finished_reg   <= finished_next;
            done_reg       <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        dir_reg    <= dir_next;
        rd_row_reg <= rd_row_next;
        rd_col_reg <= rd_col_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Carved map, one bit per grid position.
    mbg_ram #(
        .DW (1),
        .AW (MAP_AW)
    ) u_map (
        .clk   (clk),
        .we    (map_we),
        .addr  (map_addr),
        .wdata (map_wdata),
        .rdata (map_rdata)
    );

    // Ancestor stack of walker positions.
    mbg_ram #(
        .DW (2 * DIM_W),
        .AW (STACK_AW)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .addr  (stk_addr),
        .wdata (stk_wdata),
        .rdata (stk_rdata)
    );

    // A result appears only while the sequencer is idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Without a new item the strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !start) |=> !done)
        else $error("result strobe longer than one cycle");

    // An accepted start or read always makes the block busy.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.action != ACT_STEP) |=> busy)
        else $error("accepted item did not start work");

    // The stack never holds more than its depth.
    a_depth_max: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CNT_W'(STACK_DEPTH))
        else $error("stack depth overflow");

endmodule

`default_nettype wire

### tb/sv/maze_backtracker_generator_tb.sv
// Testbench for the maze backtracker generator: directed and random items, self-checking.
// Depends on mbg_pkg and maze_backtracker_generator; keeps its own copy of the maze state
// to predict every result.
`timescale 1ns / 1ps

module maze_backtracker_generator_tb;
    import mbg_pkg::*;

    localparam int LAST_DIR = 3;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          start = 1'b0;
    logic          busy;
    item_t         item = '0;
    logic          done;
    result_t       result;
    logic          cfg_we = 1'b0;
    logic          cfg_index = CFG_WIDTH;
    logic [REG_W-1:0] cfg_data = '0;

    maze_backtracker_generator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Mirror of the maze state.
    bit          carved[MAX_DIM*MAX_DIM];
    int          anc_row[STACK_DEPTH];
    int          anc_col[STACK_DEPTH];
    int          grid_w = 11, grid_h = 11;
    int          walk_r = 1, walk_c = 1;
    int          depth = 0, deepest = 0;
    int          goal_r = 0, goal_c = 0;
    bit          goal_set = 0;
    int          cells_left = 0;
    bit          walk_done = 1;

    result_t     pending_results[$];
    int          errors = 0;
    int          items_sent = 0;
    int          event_tally[8];
    bit          no_gaps = 0;

    function automatic int clamp_dim(int v);
        if (v < 3) return 3;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic bit is_maze_cell(int r, int c);
        int h, w;
        h = clamp_dim(grid_h);
        w = clamp_dim(grid_w);
        return r >= 1 && r <= h - 2 && r[0] && c >= 1 && c <= w - 2 && c[0];
    endfunction

    function automatic bit is_fresh(int r, int c);
        if (!is_maze_cell(r, c)) return 0;
        return !carved[r*MAX_DIM + c];
    endfunction

    function automatic logic [2:0] code_of_cell(int r, int c);
        bit cut;
        cut = carved[r*MAX_DIM + c];
        if (cut && r == 1 && c == 1) return CELL_START;
        if (goal_set && r == goal_r && c == goal_c) return CELL_GOAL;
        if (cut) return CELL_PASSAGE;
        if (is_maze_cell(r, c)) return CELL_UNVISITED;
        return CELL_WALL;
    endfunction

    // Advance the mirror by one item and return the result it causes.
    function automatic result_t predict_walk(item_t it);
        result_t res;
        int ofs_r[4], ofs_c[4];
        bit open_dir[4];
        bit any_open;
        int tr, tc, h, w;
        ofs_r = '{2, -2, 0, 0};
        ofs_c = '{0, 0, 2, -2};
        res = '0;
        if (it.action == ACT_START) begin
            h = clamp_dim(grid_h);
            w = clamp_dim(grid_w);
            foreach (carved[i]) carved[i] = 0;
            carved[MAX_DIM + 1] = 1;
            walk_r = 1; walk_c = 1;
            depth = 0; deepest = 0;
            goal_r = 0; goal_c = 0; goal_set = 0;
            cells_left = ((h - 1) / 2) * ((w - 1) / 2) - 1;
            walk_done = 0;
            res.event_res = EV_STARTED;
        end else if (it.action == ACT_READ || it.action == ACT_SPARE) begin
            res.cell_code = code_of_cell(it.read_row, it.read_col);
            res.event_res = EV_READ;
        end else if (walk_done || cells_left == 0) begin
            walk_done = 1;
            res.event_res = EV_FINISHED;
        end else begin
            any_open = 0;
            for (int k = 0; k <= LAST_DIR; k++) begin
                open_dir[k] = is_fresh(walk_r + ofs_r[k], walk_c + ofs_c[k]);
                any_open |= open_dir[k];
            end
            if (!any_open) begin
                if (depth == 0) begin
                    walk_done = 1;
                    res.event_res = EV_FINISHED;
                end else begin
                    depth--;
                    walk_r = anc_row[depth];
                    walk_c = anc_col[depth];
                    res.event_res = EV_BACK;
                end
            end else if (!open_dir[it.rand_dir] || depth >= STACK_DEPTH) begin
                res.event_res = EV_REJECT;
            end else begin
                tr = walk_r + ofs_r[it.rand_dir];
                tc = walk_c + ofs_c[it.rand_dir];
                anc_row[depth] = walk_r;
                anc_col[depth] = walk_c;
                depth++;
                carved[(walk_r + ofs_r[it.rand_dir] / 2)*MAX_DIM
                       + walk_c + ofs_c[it.rand_dir] / 2] = 1;
                carved[tr*MAX_DIM + tc] = 1;
                walk_r = tr;
                walk_c = tc;
                if (cells_left > 0) cells_left--;
                if (depth > deepest) begin
                    deepest = depth;
                    goal_r = tr; goal_c = tc; goal_set = 1;
                end
                res.event_res = EV_MOVED;
            end
        end
        res.walker_row      = walk_r;
        res.walker_col      = walk_c;
        res.goal_row        = goal_r;
        res.goal_col        = goal_c;
        res.stack_depth     = depth;
        res.remaining_cells = cells_left;
        event_tally[res.event_res]++;
        return res;
    endfunction

    // Send one item after a random gap and record its expected result on acceptance.
    task automatic send_item(item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        item  = it;
        forever begin
            @(posedge clk);
            if (!busy) break;
        end
        pending_results.push_back(predict_walk(it));
        items_sent++;
    endtask

    task automatic send_action(logic [1:0] act, logic [1:0] dir, int r, int c);
        item_t it;
        it.action   = act;
        it.rand_dir = dir;
        it.read_row = r;
        it.read_col = c;
        send_item(it);
    endtask

    // Wait until every expected result has come and the block is idle.
    task automatic drain;
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0 || busy) @(posedge clk);
    endtask

    // Register write, only issued after drain.
    task automatic write_dim(logic idx, int value);
        drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_WIDTH) grid_w = value & 127;
        else grid_h = value & 127;
    endtask

    task automatic report_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: mismatch in %s: expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Compare each result with the oldest expectation.
    always @(posedge clk) begin
        result_t exp_r;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, event %0d", $time, result.event_res);
            end else begin
                exp_r = pending_results.pop_front();
                report_field("event_res", exp_r.event_res, result.event_res);
                report_field("walker_row", exp_r.walker_row, result.walker_row);
                report_field("walker_col", exp_r.walker_col, result.walker_col);
                report_field("cell_code", exp_r.cell_code, result.cell_code);
                report_field("goal_row", exp_r.goal_row, result.goal_row);
                report_field("goal_col", exp_r.goal_col, result.goal_col);
                report_field("stack_depth", exp_r.stack_depth, result.stack_depth);
                report_field("remaining_cells", exp_r.remaining_cells,
                             result.remaining_cells);
            end
        end
    end

    // Reads and steps before the first start.
    task automatic test_before_start;
        send_action(ACT_READ, DIR_ROW_INC, 1, 1);
        send_action(ACT_READ, DIR_ROW_INC, 63, 63);
        send_action(ACT_READ, DIR_ROW_INC, 0, 2);
        send_action(ACT_STEP, DIR_COL_INC, 0, 0);
    endtask

    // Small maze walked through by hand: every direction, start and goal reads.
    task automatic test_small_maze;
        write_dim(CFG_WIDTH, 5);
        write_dim(CFG_HEIGHT, 5);
        send_action(ACT_START, DIR_ROW_INC, 0, 0);
        send_action(ACT_STEP, DIR_ROW_DEC, 0, 0);
        send_action(ACT_STEP, DIR_COL_DEC, 0, 0);
        send_action(ACT_STEP, DIR_COL_INC, 0, 0);
        send_action(ACT_STEP, DIR_ROW_INC, 0, 0);
        send_action(ACT_STEP, DIR_COL_DEC, 0, 0);
        send_action(ACT_READ, DIR_ROW_INC, 1, 1);
        send_action(ACT_SPARE, DIR_ROW_INC, goal_r, goal_c);
        send_action(ACT_READ, DIR_ROW_INC, 1, 2);
        send_action(ACT_READ, DIR_ROW_INC, 2, 2);
        repeat (3) send_action(ACT_STEP, DIR_ROW_DEC, 0, 0);
        send_action(ACT_STEP, DIR_ROW_INC, 0, 0);
    endtask

    // Dimensions below the minimum and above the maximum.
    task automatic test_dim_extremes;
        write_dim(CFG_WIDTH, 0);
        write_dim(CFG_HEIGHT, 2);
        send_action(ACT_START, DIR_ROW_INC, 0, 0);
        send_action(ACT_STEP, DIR_COL_INC, 0, 0);
        send_action(ACT_READ, DIR_ROW_INC, 1, 1);
        write_dim(CFG_WIDTH, 127);
        write_dim(CFG_HEIGHT, 65);
        send_action(ACT_START, DIR_ROW_INC, 0, 0);
        for (int k = 0; k < 6; k++) send_action(ACT_STEP, k % 4, 0, 0);
        send_action(ACT_READ, DIR_ROW_INC, 61, 61);
        send_action(ACT_READ, DIR_ROW_INC, 63, 62);
    endtask

    // Shrink and grow the grid while a maze is in progress.
    task automatic test_resize_midway;
        write_dim(CFG_WIDTH, 9);
        write_dim(CFG_HEIGHT, 9);
        send_action(ACT_START, DIR_ROW_INC, 0, 0);
        repeat (12) send_action(ACT_STEP, $urandom_range(0, 3), 0, 0);
        write_dim(CFG_WIDTH, 4);
        repeat (10) send_action(ACT_STEP, $urandom_range(0, 3), 0, 0);
        write_dim(CFG_WIDTH, 13);
        write_dim(CFG_HEIGHT, 7);
        repeat (20) send_action(ACT_STEP, $urandom_range(0, 3), 0, 0);
        send_action(ACT_READ, DIR_ROW_INC, 5, 11);
    endtask

    function automatic int draw_dim();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return $urandom_range(3, 15);
        if (pick < 88) return $urandom_range(0, 2);
        if (pick < 95) return $urandom_range(16, 64);
        return $urandom_range(65, 127);
    endfunction

    // Random mazes: mostly steps, some reads, some noise.
    task automatic test_random_mazes(int budget);
        int quota, pick, sess;
        quota = items_sent + budget;
        sess = 0;
        while (items_sent < quota) begin
            write_dim(CFG_WIDTH, draw_dim());
            write_dim(CFG_HEIGHT, draw_dim());
            no_gaps = (sess % 4 == 3);
            if (sess % 5 == 2) begin
                drain();
            end
            send_action(ACT_START, $urandom_range(0, 3), $urandom_range(0, 63),
                        $urandom_range(0, 63));
            for (int n = 0; n < 300 && items_sent < quota; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    send_action(ACT_STEP, $urandom_range(0, 3), $urandom_range(0, 63),
                                $urandom_range(0, 63));
                else if (pick < 95)
                    send_action($urandom_range(2, 3), $urandom_range(0, 3),
                                $urandom_range(0, 63), $urandom_range(0, 63));
                else if (pick < 97)
                    send_action(ACT_READ, DIR_ROW_INC, goal_r, goal_c);
                else
                    send_action(ACT_STEP, $urandom_range(0, 3), 0, 0);
                if (walk_done && $urandom_range(0, 3) == 0) break;
            end
            sess++;
        end
        no_gaps = 0;
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_before_start();
        test_small_maze();
        test_dim_extremes();
        test_resize_midway();
        test_random_mazes(1600);
        drain();
        repeat (20) @(posedge clk);
        $display("Covered %0d items: %0d moves, %0d backtracks, %0d rejected draws,",
                 items_sent, event_tally[EV_MOVED], event_tally[EV_BACK],
                 event_tally[EV_REJECT]);
        $display("  %0d finishes, %0d starts and %0d cell reads; %0d mismatches.",
                 event_tally[EV_FINISHED], event_tally[EV_STARTED],
                 event_tally[EV_READ], errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
